// ===== rtl/pswrl_pkg.sv =====
// ----------------------------------------------------------------------------
// pswrl_pkg
// Types and constants shared by the per-source window rate limiter.
// ----------------------------------------------------------------------------
package pswrl_pkg;

   // Request item
   typedef struct packed {
      logic [31:0] source_ip;
      logic [31:0] now_seconds;
   } req_type;

   // Result item
   typedef struct packed {
      logic        limited;
      logic [2:0]  outcome;
   } rsp_type;

   // Outcome codes
   localparam logic [2:0] OUT_COUNTED = 3'd0;
   localparam logic [2:0] OUT_RESTART = 3'd1;
   localparam logic [2:0] OUT_NEW     = 3'd2;
   localparam logic [2:0] OUT_OVER    = 3'd3;
   localparam logic [2:0] OUT_FULL    = 3'd4;

   // CSR map: one 32-bit word per register
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic REG_WINDOW_SECONDS = 1'b0;
   localparam logic REG_MAX_REQUESTS   = 1'b1;

   localparam logic [15:0] WINDOW_SECONDS_RST = 16'd60;
   localparam logic [15:0] MAX_REQUESTS_RST   = 16'd5;

   // One table entry
   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] count;
      logic [31:0] start;
   } entry_type;

   // Per-entry decision from the evaluator
   typedef struct packed {
      logic        match;     // entry holds the request's source
      logic        evict;     // used, expired, not matched: drop it
      logic        free;      // entry is free after this step
      logic        limited;   // valid with match
      logic [2:0]  outcome;   // valid with match
      logic        wr_en;     // matched entry needs write-back
      entry_type   wr_entry;  // write-back data
   } eval_type;

endpackage

// ===== rtl/pswrl_eval.sv =====
// ----------------------------------------------------------------------------
// pswrl_eval
// Evaluates one table entry against the current request: match, expiry,
// limit check and the updated entry for write-back.
// ----------------------------------------------------------------------------
module pswrl_eval
   import pswrl_pkg::*;
(
   input  entry_type   entry,
   input  logic        entry_valid,
   input  logic [31:0] src,
   input  logic [31:0] now,
   input  logic [15:0] window_seconds,
   input  logic [15:0] max_requests,
   output eval_type    result
);

   logic [31:0] age;
   logic        expired;
   logic        match;

   // wrapping age, mod 2^32
   assign age     = now - entry.start;
   assign expired = age >= {16'd0, window_seconds};
   assign match   = entry_valid && (src != 32'd0) && (entry.addr == src);

   always_comb begin
      result          = '0;
      result.match    = match;
      result.evict    = entry_valid && !match && expired;
      result.free     = !entry_valid || (!match && expired);
      result.wr_entry = entry;
      if (match) begin
         if (expired) begin
            result.outcome        = OUT_RESTART;
            result.wr_en          = 1'b1;
            result.wr_entry.count = 16'd1;
            result.wr_entry.start = now;
         end else if (entry.count >= max_requests) begin
            result.limited = 1'b1;
            result.outcome = OUT_OVER;
         end else begin
            result.outcome        = OUT_COUNTED;
            result.wr_en          = 1'b1;
            result.wr_entry.count = entry.count + 16'd1;
         end
      end
   end

endmodule

// ===== rtl/per_source_window_rate_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// per_source_window_rate_limiter_unit
// Flow: an accepted request scans the table in order, reading one entry per
//   cycle from the table memory, until a match or the last entry; the result
//   then passes through ST_RESP into the output register. A new request is
//   taken only after that, back in ST_IDLE.
// Reset: synchronous; clears the per-entry valid bits (all entries free),
//   the CSRs to window 60 s / limit 5, and the handshake state.
// ----------------------------------------------------------------------------
module per_source_window_rate_limiter_unit
   import pswrl_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 16
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // ------------------------------------------------------------------
   // CSRs
   // ------------------------------------------------------------------
   logic [15:0] window_ff, window_in;
   logic [15:0] max_req_ff, max_req_in;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      window_in  = window_ff;
      max_req_in = max_req_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_WINDOW_SECONDS: window_in  = csr_pwdata[15:0];
            REG_MAX_REQUESTS:   max_req_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WINDOW_SECONDS: csr_prdata = {16'd0, window_ff};
         REG_MAX_REQUESTS:   csr_prdata = {16'd0, max_req_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Table memory: address/count/window start per entry. Entry contents
   // are only meaningful while its valid bit is set; valid = used.
   // ------------------------------------------------------------------
   entry_type                mem [TABLE_ENTRIES];
   entry_type                rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     mem_we;
   logic [IDX_W-1:0]         wr_idx;
   entry_type                wr_data;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Scan control
   // ------------------------------------------------------------------
   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;   // entry whose data is in rd_data_ff
   logic             have_free_ff, have_free_in;
   logic [IDX_W-1:0] free_at_ff, free_at_in;
   rsp_type          res_ff, res_in;           // finished result awaiting output reg
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   eval_type         ev;
   logic             last;
   logic             free_nx;
   logic [IDX_W-1:0] free_at_nx;

   pswrl_eval u_eval (
      .entry          (rd_data_ff),
      .entry_valid    (valid_ff[chk_idx_ff]),
      .src            (req_ff.source_ip),
      .now            (req_ff.now_seconds),
      .window_seconds (window_ff),
      .max_requests   (max_req_ff),
      .result         (ev)
   );

   assign last       = (chk_idx_ff == LAST_IDX);
   assign free_nx    = have_free_ff || ev.free;
   assign free_at_nx = have_free_ff ? free_at_ff : chk_idx_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      chk_idx_in   = chk_idx_ff;
      have_free_in = have_free_ff;
      free_at_in   = free_at_ff;
      res_in       = res_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      rd_addr      = '0;
      mem_we       = 1'b0;
      wr_idx       = chk_idx_ff;
      wr_data      = ev.wr_entry;

      case (state_ff)
         ST_IDLE: begin
            // entry 0 is read every idle cycle, so it is ready on accept
            req_ready = 1'b1;
            if (req_valid) begin
               req_in       = req_data;
               chk_idx_in   = '0;
               have_free_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end

         ST_SCAN: begin
            rd_addr = last ? '0 : chk_idx_ff + IDX_W'(1);
            if (ev.match) begin
               res_in   = '{limited: ev.limited, outcome: ev.outcome};
               mem_we   = ev.wr_en;
               state_in = ST_RESP;
            end else begin
               if (ev.evict) begin
                  valid_in[chk_idx_ff] = 1'b0;
               end
               have_free_in = free_nx;
               free_at_in   = free_at_nx;
               chk_idx_in   = chk_idx_ff + IDX_W'(1);
               if (last) begin
                  state_in = ST_RESP;
                  if (!free_nx) begin
                     res_in = '{limited: 1'b1, outcome: OUT_FULL};
                  end else begin
                     res_in = '{limited: 1'b0, outcome: OUT_NEW};
                     // address zero is answered but never stored
                     if (req_ff.source_ip != 32'd0) begin
                        mem_we               = 1'b1;
                        wr_idx               = free_at_nx;
                        wr_data              = '{addr:  req_ff.source_ip,
                                                 count: 16'd1,
                                                 start: req_ff.now_seconds};
                        valid_in[free_at_nx] = 1'b1;
                     end
                  end
               end
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_SECONDS_RST;
         max_req_ff   <= MAX_REQUESTS_RST;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         max_req_ff   <= max_req_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      chk_idx_ff   <= chk_idx_in;
      have_free_ff <= have_free_in;
      free_at_ff   <= free_at_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/pswrl_checker.sv =====
// ----------------------------------------------------------------------------
// pswrl_checker
// Port-level checks for the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module pswrl_checker
   import pswrl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // rejection flag agrees with the outcome code
   a_limited: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.limited ==
                    (rsp_data.outcome == OUT_OVER || rsp_data.outcome == OUT_FULL))
      else $error("limited does not match outcome");

   // only defined outcome codes leave the block
   a_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.outcome <= OUT_FULL)
      else $error("undefined outcome code");

   // every accept starts a scan, so no item is taken directly after another
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted during a scan");

endmodule

bind per_source_window_rate_limiter_unit pswrl_checker u_pswrl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
